/* src/rwub_pkg.sv */
`default_nettype none

package rwub_pkg;

   localparam int WORD_W    = 32;
   localparam int VAL_W     = WORD_W + 1;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DENOM = 3'd3;

   localparam logic MODE_UNIFORM = 1'b0;
   localparam logic MODE_BERN    = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PRESAMPLE,
      PH_REFINE,
      PH_BERN,
      PH_TEST_BOUND,
      PH_TEST_CAND
   } phase_type;

   typedef enum logic [1:0] {
      KS_LOAD,
      KS_SCAN,
      KS_DONE
   } kscan_state_type;

   typedef struct packed {
      logic              mode;
      logic [VAL_W-1:0]  n;
      logic [WORD_W-1:0] numer;
      logic [WORD_W-1:0] denom;
      logic              degen;
      logic              restart;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] k;
   } klen_type;

   typedef struct packed {
      logic             ge;
      logic             eq;
      logic [VAL_W-1:0] diff;
   } alu_res_type;

endpackage

`default_nettype wire

/* src/rwub_if.sv */
`default_nettype none

interface rwub_req_if import rwub_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

interface rwub_rsp_if import rwub_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] sample;
   logic              last_of_word;

   modport source (output valid, output sample, output last_of_word, input ready);
   modport sink   (input valid, input sample, input last_of_word, output ready);
endinterface

`default_nettype wire

/* src/rwub_alu.sv */
`default_nettype none

module rwub_alu import rwub_pkg::*; (
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output alu_res_type      res
);

   assign res.ge   = (a >= b);
   assign res.eq   = (a == b);
   assign res.diff = a - b;

endmodule

`default_nettype wire

/* src/rwub_kscan.sv */
`default_nettype none

module rwub_kscan import rwub_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [WORD_W-1:0] range_n,
   output klen_type          klen
);

   kscan_state_type   state_ff, state_in;
   logic [WORD_W-1:0] m_ff, m_in;
   logic [CNT_W-1:0]  kc_ff, kc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_LOAD;
      end else begin
         state_ff <= state_in;
      end
      m_ff  <= m_in;
      kc_ff <= kc_in;
   end

   // bit length of range_n - 1, one bit position a cycle from the top
   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      kc_in    = kc_ff;
      case (state_ff)
         KS_LOAD: begin
            m_in     = range_n - WORD_W'(1);
            kc_in    = CNT_W'(WORD_W);
            state_in = KS_SCAN;
         end
         KS_SCAN: begin
            if (m_ff[WORD_W-1] || kc_ff == '0) begin
               state_in = KS_DONE;
            end else begin
               m_in  = m_ff << 1;
               kc_in = kc_ff - CNT_W'(1);
            end
         end
         KS_DONE: begin
            state_in = KS_DONE;
         end
         default: begin
            state_in = KS_LOAD;
         end
      endcase
      if (restart) begin
         state_in = KS_LOAD;
      end
   end

   assign klen.valid = (state_ff == KS_DONE);
   assign klen.k     = kc_ff;

endmodule

`default_nettype wire

/* src/rwub_engine.sv */
`default_nettype none

module rwub_engine import rwub_pkg::*; #(
   parameter int EFF_BITS = 32
) (
   input  logic   clock,
   input  logic   reset,
   input  cfg_type  cfg,
   input  klen_type klen,
   rwub_req_if.sink   req,
   rwub_rsp_if.source rsp
);

   localparam int POS_W = $clog2(EFF_BITS + 1);
   localparam logic [POS_W-1:0] POS_END = POS_W'(EFF_BITS);

   logic              busy_ff, busy_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [VAL_W-1:0]  cand_ff, cand_in;
   logic [VAL_W-1:0]  bound_ff, bound_in;
   logic [VAL_W-1:0]  resid_ff, resid_in;
   logic              pend_v_ff, pend_v_in;
   logic [WORD_W-1:0] pend_s_ff, pend_s_in;
   logic              out_v_ff, out_v_in;
   logic [WORD_W-1:0] out_s_ff, out_s_in;
   logic              out_last_ff, out_last_in;

   logic [WORD_W-1:0] word_sh;
   logic              bit_cur;
   logic [CNT_W-1:0]  room;
   logic [CNT_W-1:0]  chunk_len;
   logic [CNT_W-1:0]  left_rem;
   logic [VAL_W-1:0]  chunk;
   logic [VAL_W-1:0]  cand_pre;
   logic [VAL_W-1:0]  alu_a, alu_b;
   alu_res_type       alu;
   logic              bern_y;
   logic [VAL_W-1:0]  bern_next;
   logic              can_push;
   logic              word_end;
   logic              done_now;
   logic              stall;
   logic              res_done;
   logic [WORD_W-1:0] res_val;

   rwub_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .res (alu)
   );

   assign word_sh   = word_ff >> pos_ff;
   assign bit_cur   = word_sh[0];
   assign room      = CNT_W'(POS_END - pos_ff);
   assign chunk_len = (left_ff < room) ? left_ff : room;
   assign left_rem  = left_ff - chunk_len;
   assign chunk     = {1'b0, word_sh} & ~({VAL_W{1'b1}} << chunk_len);
   // earlier presample bits sit above the chunk from this word
   assign cand_pre  = (cand_ff << chunk_len) | chunk;

   always_comb begin
      case (phase_ff)
         PH_TEST_BOUND: alu_a = bound_ff;
         PH_TEST_CAND:  alu_a = cand_ff;
         default:       alu_a = resid_ff;
      endcase
   end
   assign alu_b     = (phase_ff == PH_BERN) ? {1'b0, cfg.denom} : cfg.n;
   assign bern_y    = alu.ge && !alu.eq;
   assign bern_next = bern_y ? alu.diff : resid_ff;

   assign can_push = !out_v_ff || rsp.ready;
   // a pending test still belongs to this word
   assign word_end = busy_ff && (pos_ff == POS_END) && (phase_ff != PH_TEST_BOUND)
                     && (phase_ff != PH_TEST_CAND);
   assign done_now = busy_ff && !word_end
                     && ((phase_ff == PH_TEST_CAND && !alu.ge)
                         || (phase_ff == PH_BERN && (alu.eq || bit_cur)));
   // one finished sample is held back until we know whether it closes the word
   assign stall    = done_now && pend_v_ff && !can_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pos_ff    <= '0;
         phase_ff  <= PH_IDLE;
         left_ff   <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      word_ff     <= word_in;
      cand_ff     <= cand_in;
      bound_ff    <= bound_in;
      resid_ff    <= resid_in;
      pend_s_ff   <= pend_s_in;
      out_s_ff    <= out_s_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      busy_in     = busy_ff;
      word_in     = word_ff;
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      left_in     = left_ff;
      cand_in     = cand_ff;
      bound_in    = bound_ff;
      resid_in    = resid_ff;
      pend_v_in   = pend_v_ff;
      pend_s_in   = pend_s_ff;
      out_v_in    = out_v_ff;
      out_s_in    = out_s_ff;
      out_last_in = out_last_ff;
      res_done    = 1'b0;
      res_val     = '0;

      if (out_v_ff && rsp.ready) begin
         out_v_in = 1'b0;
      end

      if (req.valid && !busy_ff) begin
         busy_in = 1'b1;
         word_in = req.random_word;
         pos_in  = '0;
         if (cfg.degen) begin
            // no bits needed: one fixed result closes the word
            phase_in  = PH_IDLE;
            pos_in    = POS_END;
            pend_v_in = 1'b1;
            pend_s_in = (cfg.mode == MODE_BERN) ? WORD_W'(1) : '0;
         end
      end else if (word_end) begin
         if (!pend_v_ff) begin
            busy_in = 1'b0;
         end else if (can_push) begin
            out_v_in    = 1'b1;
            out_s_in    = pend_s_ff;
            out_last_in = 1'b1;
            pend_v_in   = 1'b0;
            busy_in     = 1'b0;
         end
      end else if (busy_ff && !stall) begin
         case (phase_ff)
            PH_IDLE: begin
               if (cfg.mode == MODE_BERN) begin
                  resid_in = {cfg.numer, 1'b0};
                  phase_in = PH_BERN;
               end else if (klen.valid) begin
                  left_in  = klen.k;
                  cand_in  = '0;
                  bound_in = VAL_W'(1) << klen.k;
                  phase_in = PH_PRESAMPLE;
               end
            end
            PH_PRESAMPLE: begin
               cand_in = cand_pre;
               left_in = left_rem;
               pos_in  = pos_ff + POS_W'(chunk_len);
               if (left_rem == '0) begin
                  phase_in = PH_TEST_BOUND;
               end
            end
            PH_TEST_BOUND: begin
               if (alu.ge) begin
                  bound_in = alu.diff;
                  phase_in = PH_TEST_CAND;
               end else begin
                  phase_in = PH_REFINE;
               end
            end
            PH_TEST_CAND: begin
               if (!alu.ge) begin
                  res_done = 1'b1;
                  res_val  = cand_ff[WORD_W-1:0];
               end else begin
                  cand_in  = alu.diff;
                  phase_in = PH_REFINE;
               end
            end
            PH_REFINE: begin
               pos_in   = pos_ff + POS_W'(1);
               bound_in = bound_ff << 1;
               cand_in  = {cand_ff[VAL_W-2:0], bit_cur};
               phase_in = PH_TEST_BOUND;
            end
            PH_BERN: begin
               pos_in = pos_ff + POS_W'(1);
               if (alu.eq) begin
                  res_done = 1'b1;
                  res_val  = WORD_W'(bit_cur);
               end else if (bit_cur) begin
                  res_done = 1'b1;
                  res_val  = WORD_W'(bern_y);
               end else begin
                  resid_in = bern_next << 1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (res_done) begin
            if (pend_v_ff) begin
               out_v_in    = 1'b1;
               out_s_in    = pend_s_ff;
               out_last_in = 1'b0;
            end
            pend_v_in = 1'b1;
            pend_s_in = res_val;
            phase_in  = PH_IDLE;
         end
      end

      // any register write drops the sample in progress
      if (cfg.restart) begin
         phase_in = PH_IDLE;
         left_in  = '0;
      end
   end

   assign req.ready        = !busy_ff;
   assign rsp.valid        = out_v_ff;
   assign rsp.sample       = out_s_ff;
   assign rsp.last_of_word = out_last_ff;

`ifndef SYNTH
   a_cand_below_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REFINE || phase_ff == PH_TEST_BOUND) |-> (cand_ff < bound_ff))
      else $error("candidate not below bound");

   a_bound_below_2n: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REFINE || phase_ff == PH_TEST_BOUND)
      |-> ({1'b0, bound_ff} < {cfg.n, 1'b0}))
      else $error("bound reached twice the range");

   a_pend_flushed: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !pend_v_ff)
      else $error("held result left behind at word end");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_END)
      else $error("bit position past end of word");
`endif

endmodule

`default_nettype wire

/* src/random_word_uniform_bernoulli_sampler.sv */
// Draws samples from 32-bit random words, whose bits are used least significant first
// (only the low WORD_BITS bits when WORD_BITS is below 32). In uniform mode each sample
// lies in [0, range_n) (range_n of zero means 2^32), drawn by the Fast Dice Roller; in
// Bernoulli mode each sample is 1 with probability numerator/denominator. A sample may
// span words; results of one word come out in order and the last one carries
// last_of_word. With range_n of one in uniform mode, or numerator at or above
// denominator in Bernoulli mode, every word gives exactly one fixed result. Timing: the
// block takes one word at a time and is not ready while it works on it. The range and
// Bernoulli compares and subtracts share one 33-bit unit. Each sample starts with a
// set-up step; after it a Bernoulli bit needs only its compare, a presample chunk is
// loaded and then tested against the bound and, if that passes, the candidate, and a
// uniform refinement bit is shifted in and then put through the same tests. The word
// ends with a closing step; a word with a fixed result goes straight to it. After any
// register write the bit length of range_n - 1 is found again by a scan from the top
// bit, during which uniform sampling waits. The core stalls when a new result is ready
// while both the output register and the held-back result are full and the output is
// not taken.
`default_nettype none

module random_word_uniform_bernoulli_sampler import rwub_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   rwub_req_if.sink             req_if,
   rwub_rsp_if.source           rsp_if
);

   localparam int EFF_BITS = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;

   logic              mode_ff, mode_in;
   logic [WORD_W-1:0] range_ff, range_in;
   logic [WORD_W-1:0] numer_ff, numer_in;
   logic [WORD_W-1:0] denom_ff, denom_in;
   logic              restart;
   cfg_type           cfg;
   klen_type          klen;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_UNIFORM;
         range_ff <= WORD_W'(2);
         numer_ff <= WORD_W'(1);
         denom_ff <= WORD_W'(2);
      end else begin
         mode_ff  <= mode_in;
         range_ff <= range_in;
         numer_ff <= numer_in;
         denom_ff <= denom_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      range_in = range_ff;
      numer_in = numer_ff;
      denom_in = denom_ff;
      restart  = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[0];
               restart = 1'b1;
            end
            CSR_RANGE: begin
               range_in = csr_wdata;
               restart  = 1'b1;
            end
            CSR_NUMER: begin
               numer_in = csr_wdata;
               restart  = 1'b1;
            end
            CSR_DENOM: begin
               denom_in = csr_wdata;
               restart  = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.n       = (range_ff == '0) ? {1'b1, {WORD_W{1'b0}}} : {1'b0, range_ff};
   // numerator saturates at the denominator
   assign cfg.numer   = (numer_ff > denom_ff) ? denom_ff : numer_ff;
   assign cfg.denom   = denom_ff;
   assign cfg.degen   = (mode_ff == MODE_UNIFORM) ? (range_ff == WORD_W'(1))
                                                  : (numer_ff >= denom_ff);
   assign cfg.restart = restart;

   rwub_kscan u_kscan (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .range_n (range_ff),
      .klen    (klen)
   );

   rwub_engine #(
      .EFF_BITS (EFF_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .klen  (klen),
      .req   (req_if),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire
